// File: sv/nearest_neighbor_ratio_test_assert.svh
// Assertion macros for the nearest neighbor ratio test block.
`ifndef NEAREST_NEIGHBOR_RATIO_TEST_ASSERT_SVH
`define NEAREST_NEIGHBOR_RATIO_TEST_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define NNRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define NNRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define NNRT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NNRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/nnrt_pkg.sv
// Shared widths, defaults and reset values for the nearest neighbor ratio test.
package nnrt_pkg;

   localparam int DIST_PORT_W  = 32;      // width of the distance field
   localparam int IDX_W        = 16;      // width of row and column numbers
   localparam int RATIO_W      = 16;      // ratio threshold, unsigned Q0.16

   localparam int MAX_FEATURES_DEFAULT = 65536;
   localparam int DIST_BITS_DEFAULT    = 32;

   // 0.6 in Q0.16, rounded
   localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd39322;

   localparam logic [IDX_W-1:0] IDX_MAX = '1;

endpackage

// File: sv/nearest_neighbor_ratio_test.sv
// Nearest neighbor ratio test: streaming best/second-best search with ratio check.
// Throughput: one distance item per cycle while req_ready is high; the row tracker
// updates in the accept cycle. A row's result reaches rsp_valid through the row-end
// record, then the multiply register, then the compare into the output register.
// Rows that fail the test or have one candidate give no item; they cost no output slot.
// Reset (synchronous, active high) empties the pipeline, zeroes counts, ratio = 0.6 Q0.16.
`include "nearest_neighbor_ratio_test_assert.svh"

module nearest_neighbor_ratio_test #(
   parameter int MAX_FEATURES = nnrt_pkg::MAX_FEATURES_DEFAULT,
   parameter int DIST_BITS    = nnrt_pkg::DIST_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // candidate distance stream
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [nnrt_pkg::DIST_PORT_W-1:0]  req_distance,
   input  logic                              req_last_in_row,
   // accepted matches
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [nnrt_pkg::IDX_W-1:0]        rsp_query_index,
   output logic [nnrt_pkg::IDX_W-1:0]        rsp_match_index,
   // ratio threshold write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nnrt_pkg::RATIO_W-1:0]      csr_ratio_threshold
);

   // Distances beyond the port width cannot arrive, so storage stops there.
   localparam int DW      = (DIST_BITS < nnrt_pkg::DIST_PORT_W) ?
                            DIST_BITS : nnrt_pkg::DIST_PORT_W;
   localparam int COL_CAP = (MAX_FEATURES - 1 < 65535) ? (MAX_FEATURES - 1) : 65535;
   localparam int CW      = (COL_CAP < 2) ? 1 : $clog2(COL_CAP + 1);
   localparam int PW      = DW + nnrt_pkg::RATIO_W;
   localparam logic [nnrt_pkg::IDX_W-1:0] COL_CAP_V = nnrt_pkg::IDX_W'(COL_CAP);

   // ---------------- ratio threshold register ----------------
   logic [nnrt_pkg::RATIO_W-1:0] ratio_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= nnrt_pkg::RATIO_RESET;
      end else if (csr_valid) begin
         ratio_ff <= csr_ratio_threshold;
      end
   end

   // ---------------- row tracker ----------------
   logic [DW-1:0]              best_ff, best_in;
   logic [DW-1:0]              second_ff, second_in;
   logic [CW-1:0]              bcol_ff, bcol_in;
   logic [nnrt_pkg::IDX_W-1:0] col_cnt_ff, col_cnt_in;
   logic [nnrt_pkg::IDX_W-1:0] row_ff;

   // row-end record
   logic                       e_vld_ff;
   logic [DW-1:0]              e_best_ff, e_second_ff;
   logic [CW-1:0]              e_col_ff;
   logic [nnrt_pkg::IDX_W-1:0] e_row_ff;
   logic                       e_two_ff;

   // product stage
   logic                       p_vld_ff;
   logic [PW-1:0]              p_lhs_ff, p_rhs_ff;
   logic [CW-1:0]              p_col_ff;
   logic [nnrt_pkg::IDX_W-1:0] p_row_ff;
   logic                       p_two_ff;

   // output register
   logic                       o_vld_ff;
   logic [nnrt_pkg::IDX_W-1:0] o_row_ff, o_col_ff;

   logic                       in_acc;
   logic [DW-1:0]              cand_dist;
   logic [nnrt_pkg::IDX_W-1:0] col_now;
   logic                       p_hit, o_free, p_move, p_free, e_move, e_free;

   assign cand_dist = req_distance[DW-1:0];
   assign col_now   = (col_cnt_ff < COL_CAP_V) ? col_cnt_ff : COL_CAP_V;

   // Backpressure ripples from the output register toward the input; rows that fail
   // the test are dropped at the compare and never wait on rsp_ready.
   assign o_free    = !o_vld_ff || rsp_ready;
   assign p_hit     = p_two_ff && (p_lhs_ff < p_rhs_ff);
   assign p_move    = p_vld_ff && (o_free || !p_hit);
   assign p_free    = !p_vld_ff || p_move;
   assign e_move    = e_vld_ff && p_free;
   assign e_free    = !e_vld_ff || e_move;
   assign req_ready = e_free;
   assign in_acc    = req_valid && req_ready;

   // Compare the new distance against the running best and second best.
   always_comb begin
      best_in   = best_ff;
      second_in = second_ff;
      bcol_in   = bcol_ff;
      priority if (col_cnt_ff == '0) begin
         // first candidate seeds the row
         best_in   = cand_dist;
         bcol_in   = '0;
         second_in = '1;
      end else if (cand_dist < best_ff) begin
         // old best moves down; earlier column wins ties
         second_in = best_ff;
         best_in   = cand_dist;
         bcol_in   = CW'(col_now);
      end else if (cand_dist < second_ff) begin
         second_in = cand_dist;
      end
      col_cnt_in = (col_cnt_ff == nnrt_pkg::IDX_MAX) ? col_cnt_ff :
                   col_cnt_ff + nnrt_pkg::IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff    <= '1;
         second_ff  <= '1;
         bcol_ff    <= '0;
         col_cnt_ff <= '0;
         row_ff     <= '0;
      end else if (in_acc) begin
         if (req_last_in_row) begin
            // close the row: clear tracker, advance row number
            best_ff    <= '1;
            second_ff  <= '1;
            bcol_ff    <= '0;
            col_cnt_ff <= '0;
            row_ff     <= row_ff + nnrt_pkg::IDX_W'(1);
         end else begin
            best_ff    <= best_in;
            second_ff  <= second_in;
            bcol_ff    <= bcol_in;
            col_cnt_ff <= col_cnt_in;
         end
      end
   end

   // ---------------- row-end record ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (in_acc && req_last_in_row) begin
         e_vld_ff <= 1'b1;
      end else if (e_move) begin
         e_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc && req_last_in_row) begin
         e_best_ff   <= best_in;
         e_second_ff <= second_in;
         e_col_ff    <= bcol_in;
         e_row_ff    <= row_ff;
         // two or more candidates exactly when the row was already open
         e_two_ff    <= (col_cnt_ff != '0);
      end
   end

   // ---------------- product stage ----------------
   // best < ratio * second  <=>  best * 2^16 < ratio_q16 * second
   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (e_move) begin
         p_vld_ff <= 1'b1;
      end else if (p_move) begin
         p_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (e_move) begin
         p_lhs_ff <= {e_best_ff, {nnrt_pkg::RATIO_W{1'b0}}};
         p_rhs_ff <= PW'(ratio_ff) * PW'(e_second_ff);
         p_col_ff <= e_col_ff;
         p_row_ff <= e_row_ff;
         p_two_ff <= e_two_ff;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (p_move && p_hit) begin
         o_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         o_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p_move && p_hit) begin
         o_row_ff <= p_row_ff;
         o_col_ff <= nnrt_pkg::IDX_W'(p_col_ff);
      end
   end

   assign rsp_valid       = o_vld_ff;
   assign rsp_query_index = o_row_ff;
   assign rsp_match_index = o_col_ff;

   // ---------------- checks ----------------
   `NNRT_ASSERT_NEXT(a_row_end_record, clock, reset, in_acc && req_last_in_row, e_vld_ff)
   `NNRT_ASSERT_NEXT(a_row_end_clears, clock, reset, in_acc && req_last_in_row, col_cnt_ff == '0)
   `NNRT_ASSERT_IMPLY(a_best_ordered, clock, reset, col_cnt_ff != '0, best_ff <= second_ff)

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nearest neighbor ratio test block.
module testbench;

   // Block configuration under test: the defaults of the package.
   localparam int MAX_FEATURES = nnrt_pkg::MAX_FEATURES_DEFAULT;
   localparam int DIST_BITS    = nnrt_pkg::DIST_BITS_DEFAULT;
   localparam int DIST_PORT_W  = nnrt_pkg::DIST_PORT_W;
   localparam int IDX_W        = nnrt_pkg::IDX_W;
   localparam int RATIO_W      = nnrt_pkg::RATIO_W;

   // Column numbers stop climbing here; later candidates share this column.
   localparam int COL_CAP = (MAX_FEATURES - 1 < 65535) ? MAX_FEATURES - 1 : 65535;
   localparam logic [DIST_PORT_W-1:0] DIST_MASK = DIST_PORT_W'((64'd1 << DIST_BITS) - 1);

   // A row result passes the row-end, product and output registers; allow some margin.
   localparam int ROW_END_WAIT  = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int IDLE_PERCENT  = 30;
   localparam int REPORT_LIMIT  = 10;
   localparam int LONG_ROW_LEN  = 40;

   typedef struct packed {
      logic [IDX_W-1:0] query;
      logic [IDX_W-1:0] match_col;
   } match_type;

   logic                   clock               = 1'b0;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic                   req_ready;
   logic [DIST_PORT_W-1:0] req_distance        = '0;
   logic                   req_last_in_row     = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready           = 1'b0;
   logic [IDX_W-1:0]       rsp_query_index;
   logic [IDX_W-1:0]       rsp_match_index;
   logic                   csr_valid           = 1'b0;
   logic                   csr_ready;
   logic [RATIO_W-1:0]     csr_ratio_threshold = '0;

   // Predicted state of the row tracker and the ratio register.
   logic [RATIO_W-1:0]     exp_ratio    = nnrt_pkg::RATIO_RESET;
   logic [DIST_PORT_W-1:0] trk_best     = DIST_MASK;
   logic [DIST_PORT_W-1:0] trk_second   = DIST_MASK;
   logic [IDX_W-1:0]       trk_best_col = '0;
   logic [IDX_W-1:0]       trk_cols     = '0;
   logic [IDX_W-1:0]       trk_row      = '0;

   match_type expected_matches[$];
   int        mismatch_count = 0;
   int        items_sent     = 0;
   int        quiet_cycles   = 0;
   bit        idle_en        = 1'b1;

   nearest_neighbor_ratio_test #(
      .MAX_FEATURES(MAX_FEATURES),
      .DIST_BITS   (DIST_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_distance       (req_distance),
      .req_last_in_row    (req_last_in_row),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_query_index    (rsp_query_index),
      .rsp_match_index    (rsp_match_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_ratio_threshold(csr_ratio_threshold)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Track one accepted distance; at a row end, queue the match if the ratio
   // test passes. The test is best * 2^16 < ratio * second, all unsigned.
   task automatic track_distance(input logic [DIST_PORT_W-1:0] cand_dist, input logic last);
      logic [DIST_PORT_W-1:0] d;
      logic [IDX_W-1:0]       col;
      logic [63:0]            lhs;
      logic [63:0]            rhs;
      match_type              m;
      d   = cand_dist & DIST_MASK;
      col = (trk_cols < COL_CAP) ? trk_cols : IDX_W'(COL_CAP);
      if (trk_cols == 0) begin
         // first candidate of a row seeds best; second stays empty
         trk_best     = d;
         trk_best_col = '0;
         trk_second   = DIST_MASK;
      end else if (d < trk_best) begin
         trk_second   = trk_best;
         trk_best     = d;
         trk_best_col = col;
      end else if (d < trk_second) begin
         // equal to best at another column lands here too
         trk_second = d;
      end
      if (trk_cols != nnrt_pkg::IDX_MAX) trk_cols++;
      if (last) begin
         if (trk_cols >= 2) begin
            lhs = {16'b0, trk_best, 16'b0};
            rhs = 64'(exp_ratio) * 64'(trk_second);
            if (lhs < rhs) begin
               m.query     = trk_row;
               m.match_col = trk_best_col;
               expected_matches.push_back(m);
            end
         end
         trk_row++;   // wraps at 2^16
         trk_cols     = '0;
         trk_best     = DIST_MASK;
         trk_second   = DIST_MASK;
         trk_best_col = '0;
      end
   endtask

   // Send one item, with a random gap in front when idling is on. Valid stays
   // high across back-to-back items and drops only when a gap follows.
   task automatic send_distance(input logic [DIST_PORT_W-1:0] cand_dist, input logic last);
      int unsigned gap;
      gap = 0;
      if (idle_en) while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_distance    <= cand_dist;
      req_last_in_row <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
      track_distance(cand_dist, last);
   endtask

   task automatic send_pair(input logic [DIST_PORT_W-1:0] a, input logic [DIST_PORT_W-1:0] b);
      send_distance(a, 1'b0);
      send_distance(b, 1'b1);
   endtask

   task automatic send_triple(input logic [DIST_PORT_W-1:0] a, input logic [DIST_PORT_W-1:0] b,
                              input logic [DIST_PORT_W-1:0] c);
      send_distance(a, 1'b0);
      send_distance(b, 1'b0);
      send_distance(c, 1'b1);
   endtask

   // Drop valid, wait for every queued match, then let rows that produce
   // nothing clear the pipeline.
   task automatic drain_matches();
      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (ROW_END_WAIT) @(posedge clock);
   endtask

   // Write the ratio threshold; only ever called at a row boundary.
   task automatic write_ratio(input logic [RATIO_W-1:0] value);
      drain_matches();
      if (idle_en) repeat ($urandom_range(0, 3)) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_ratio_threshold <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      exp_ratio = value;
   endtask

   // One random row. Four in ten rows are built around the ratio boundary so
   // that accept and reject both happen often; the rest are raw noise, ties and
   // extreme values.
   task automatic send_random_row();
      int unsigned            n;
      int unsigned            best_pos;
      int unsigned            second_pos;
      int unsigned            shape;
      logic [DIST_PORT_W-1:0] second_d;
      logic [DIST_PORT_W-1:0] best_d;
      logic [DIST_PORT_W-1:0] d;
      logic [63:0]            scaled;
      shape      = $urandom_range(0, 9);
      n          = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      best_pos   = $urandom_range(0, n - 1);
      second_pos = $urandom_range(0, n - 1);
      second_d   = $urandom_range(1, 32'hFFFF_FFFF);
      scaled     = (64'(exp_ratio) * 64'(second_d)) >> 16;
      if (scaled < 2) scaled = 2;
      best_d     = DIST_PORT_W'(scaled + 2 - $urandom_range(0, 4));
      for (int unsigned i = 0; i < n; i++) begin
         case (shape)
            0, 1, 2, 3: begin
               if (i == best_pos)        d = best_d;
               else if (i == second_pos) d = second_d;
               else                      d = $urandom_range(32'hFFFF_FFFF, second_d);
            end
            4, 5:    d = $urandom;
            6, 7:    d = $urandom_range(0, 7);
            8: begin
               case ($urandom_range(0, 3))
                  0:       d = '0;
                  1:       d = 32'd1;
                  2:       d = 32'hFFFF_FFFE;
                  default: d = '1;
               endcase
            end
            default: d = $urandom & $urandom;
         endcase
         send_distance(d, i == n - 1);
      end
   endtask

   // Directed rows at the reset ratio: ordering, ties, zero, single
   // candidate and extreme distances.
   task automatic test_directed_rows();
      send_pair(32'd100, 32'd200);               // best in the first column
      send_pair(32'd200, 32'd100);               // best in a later column
      send_triple(32'd10, 32'd30, 32'd20);       // second improves without a new best
      send_triple(32'd10, 32'd10, 32'd100);      // tie on best: earlier column kept, rejected
      send_triple(32'd30, 32'd10, 32'd10);       // equal distance at another column rejects
      send_pair(32'd0, 32'd0);                   // zero second best: 0 < 0 fails
      send_distance(32'd5, 1'b1);                // single candidate: no match
      send_pair(32'd0, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555);
   endtask

   // Ratio register at its extremes and between.
   task automatic test_ratio_extremes();
      write_ratio('0);
      send_pair(32'd0, 32'hFFFF_FFFF);           // nothing passes a zero ratio
      send_pair(32'd1, 32'd2);
      write_ratio('1);
      send_pair(32'd65535, 32'd65536);           // lands exactly on the boundary
      send_pair(32'd65534, 32'd65536);
      send_pair(32'd0, 32'd1);
      write_ratio(RATIO_W'($urandom));
      send_random_row();
      write_ratio(nnrt_pkg::RATIO_RESET);
   endtask

   // Bulk random rows over several ratio settings.
   task automatic test_random_rows();
      logic [RATIO_W-1:0] ratios[6];
      int                 target;
      ratios[0] = RATIO_W'($urandom);
      ratios[1] = RATIO_W'(1);
      ratios[2] = RATIO_W'($urandom);
      ratios[3] = '1;
      ratios[4] = RATIO_W'(16'h8000);
      ratios[5] = nnrt_pkg::RATIO_RESET;
      foreach (ratios[p]) begin
         write_ratio(ratios[p]);
         target = items_sent + RANDOM_ITEMS / 6;
         while (items_sent < target) send_random_row();
      end
   endtask

   // Long rows with no idling on either side: a late new best wins, and a
   // still smaller distance near the row end takes the best column again.
   task automatic test_long_rows();
      logic [DIST_PORT_W-1:0] d;
      idle_en = 1'b0;
      for (int r = 0; r < 3; r++) begin
         for (int i = 0; i < LONG_ROW_LEN; i++) begin
            if (i == LONG_ROW_LEN - 10)     d = 32'd3;
            else if (i == LONG_ROW_LEN - 2) d = DIST_PORT_W'(r);
            else                            d = 32'd1000 + (i & 255);
            send_distance(d, i == LONG_ROW_LEN - 1);
         end
      end
      repeat (4) send_random_row();
      idle_en = 1'b1;
   endtask

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", what);
   endtask

   // Result side: random stalls while idling is on, always ready otherwise.
   always @(posedge clock) begin
      rsp_ready <= idle_en ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
   end

   // Compare each accepted match with the oldest one expected.
   always @(posedge clock) begin : check_matches
      match_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            note_mismatch($sformatf("unexpected match: query %0d column %0d",
                                    rsp_query_index, rsp_match_index));
         end else begin
            want = expected_matches.pop_front();
            if (rsp_query_index !== want.query)
               note_mismatch($sformatf("query_index expected %0d actual %0d",
                                       want.query, rsp_query_index));
            if (rsp_match_index !== want.match_col)
               note_mismatch($sformatf("match_index expected %0d actual %0d (query %0d)",
                                       want.match_col, rsp_match_index, want.query));
         end
      end
   end

   // Watchdog: end the run when no channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
          || (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_rows();
      test_ratio_extremes();
      test_random_rows();
      test_long_rows();
      drain_matches();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/nnrt_pkg.sv
sv/nearest_neighbor_ratio_test.sv
dv/testbench.sv
